/* rtl/core/mphp_pkg.sv */
// ----------------------------------------------------------------------------
// mphp_pkg
// Shared types and constants for the mesh packet header parser.
// ----------------------------------------------------------------------------
package mphp_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 16;
    localparam int PATH_W = 8;
    localparam int LEN_W  = 10;
    localparam int CFG_W  = 10;

    // Field masks of the path length byte
    localparam logic [BYTE_W-1:0] HOP_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] HASH_MASK = 8'hC0;

    localparam logic [PATH_W-1:0] MAX_PATH_RST    = 8'd64;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 10'd184;
    localparam logic [LEN_W-1:0]  PAYLOAD_SAT     = 10'h3FF;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MAX_PATH    = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } t_cfg_idx;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_CODES   = 6'b000010,
        PH_PLEN    = 6'b000100,
        PH_PATH    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DROP    = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_CODE    = 3'd1,
        ROLE_PLEN    = 3'd2,
        ROLE_PATH    = 3'd3,
        ROLE_PAYLOAD = 3'd4,
        ROLE_DROP    = 3'd5
    } t_role;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_VERSION     = 4'd1,
        ST_CODES       = 4'd2,
        ST_LENGTH      = 4'd3,
        ST_HASHSIZE    = 4'd4,
        ST_PATHLONG    = 4'd5,
        ST_PATHSHORT   = 4'd6,
        ST_EMPTY       = 4'd7,
        ST_PAYLOADLONG = 4'd8
    } t_status;

    // One result beat
    typedef struct packed {
        t_role              byte_role;
        logic [BYTE_W-1:0]  byte_out;
        logic               packet_done;
        t_status            status;
        logic [1:0]         route_type;
        logic [3:0]         payload_kind;
        logic [5:0]         hop_cnt;
        logic [1:0]         hash_len;
        logic [CODE_W-1:0]  transport_first;
        logic [CODE_W-1:0]  transport_second;
        logic [LEN_W-1:0]   payload_length;
    } t_result;

endpackage

/* rtl/core/mphp_if.sv */
// ----------------------------------------------------------------------------
// mphp_if
// Valid/ready channels for packet bytes in and parse results out.
// ----------------------------------------------------------------------------
interface mphp_in_if
    import mphp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface mphp_out_if
    import mphp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        byte_role;
    logic [BYTE_W-1:0] byte_out;
    logic              packet_done;
    logic [3:0]        status;
    logic [1:0]        route_type;
    logic [3:0]        payload_kind;
    logic [5:0]        hop_cnt;
    logic [1:0]        hash_len;
    logic [CODE_W-1:0] transport_first;
    logic [CODE_W-1:0] transport_second;
    logic [LEN_W-1:0]  payload_length;

    modport source (
        output valid, input ready,
        output byte_role, output byte_out, output packet_done, output status,
        output route_type, output payload_kind, output hop_cnt, output hash_len,
        output transport_first, output transport_second, output payload_length
    );
    modport sink (
        input valid, output ready,
        input byte_role, input byte_out, input packet_done, input status,
        input route_type, input payload_kind, input hop_cnt, input hash_len,
        input transport_first, input transport_second, input payload_length
    );
endinterface

/* rtl/core/mphp_parse_core.sv */
// ----------------------------------------------------------------------------
// mphp_parse_core
// Per-packet parse state and the single-byte state update with its result.
// ----------------------------------------------------------------------------
module mphp_parse_core
    import mphp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic [PATH_W-1:0] i_max_path,
    input  logic [LEN_W-1:0]  i_max_payload,
    output t_result           o_res
);

    t_phase            r_phase,    n_phase;
    logic [1:0]        r_sub,      n_sub;
    logic [PATH_W-1:0] r_path_rem, n_path_rem;
    logic [LEN_W-1:0]  r_seen,     n_seen;
    t_status           r_err,      n_err;
    logic [1:0]        r_route,    n_route;
    logic [3:0]        r_kind,     n_kind;
    logic [5:0]        r_hops,     n_hops;
    logic [1:0]        r_hash,     n_hash;
    logic [CODE_W-1:0] r_code1,    n_code1;
    logic [CODE_W-1:0] r_code2,    n_code2;

    logic [1:0]        hash_field;
    logic [2:0]        hash_bytes;
    logic [PATH_W-1:0] path_len;
    t_role             role;
    t_phase            step_phase;
    t_status           st;

    // Path length byte decode
    always_comb begin
        hash_field = 2'((i_byte & HASH_MASK) >> 6);
        hash_bytes = {1'b0, hash_field} + 3'd1;
        path_len   = 8'(PATH_W'(i_byte & HOP_MASK) * PATH_W'(hash_bytes));
    end

    // Advance the parse state by one byte
    always_comb begin
        n_sub      = r_sub;
        n_path_rem = r_path_rem;
        n_seen     = r_seen;
        n_err      = r_err;
        n_route    = r_route;
        n_kind     = r_kind;
        n_hops     = r_hops;
        n_hash     = r_hash;
        n_code1    = r_code1;
        n_code2    = r_code2;
        step_phase = r_phase;
        role       = ROLE_DROP;

        case (r_phase)
            PH_HEADER: begin
                role       = ROLE_HEADER;
                n_sub      = '0;
                n_path_rem = '0;
                n_seen     = '0;
                n_err      = ST_OK;
                n_route    = i_byte[1:0];
                n_kind     = i_byte[5:2];
                n_hops     = '0;
                n_hash     = 2'd1;
                n_code1    = '0;
                n_code2    = '0;
                if (i_byte[7:6] != 2'd0) begin
                    n_err      = ST_VERSION;
                    step_phase = PH_DROP;
                end else if (i_byte[1:0] == 2'd0 || i_byte[1:0] == 2'd3) begin
                    step_phase = PH_CODES;
                end else begin
                    step_phase = PH_PLEN;
                end
            end
            PH_CODES: begin
                role  = ROLE_CODE;
                n_sub = r_sub + 2'd1;
                case (r_sub)
                    2'd0:    n_code1[7:0]  = i_byte;
                    2'd1:    n_code1[15:8] = i_byte;
                    2'd2:    n_code2[7:0]  = i_byte;
                    default: n_code2[15:8] = i_byte;
                endcase
                if (r_sub == 2'd3) begin
                    step_phase = PH_PLEN;
                end
            end
            PH_PLEN: begin
                role   = ROLE_PLEN;
                n_hops = 6'(i_byte & HOP_MASK);
                n_hash = hash_bytes[1:0];
                if (hash_field == 2'd3) begin
                    n_err      = ST_HASHSIZE;
                    step_phase = PH_DROP;
                end else if (path_len > i_max_path) begin
                    n_err      = ST_PATHLONG;
                    step_phase = PH_DROP;
                end else begin
                    n_path_rem = path_len;
                    step_phase = (path_len != '0) ? PH_PATH : PH_PAYLOAD;
                end
            end
            PH_PATH: begin
                role = ROLE_PATH;
                if (r_path_rem != '0) begin
                    n_path_rem = r_path_rem - 8'd1;
                end
                if (n_path_rem == '0) begin
                    step_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                role = ROLE_PAYLOAD;
                if (r_seen != PAYLOAD_SAT) begin
                    n_seen = r_seen + 10'd1;
                end
                if (r_seen >= i_max_payload) begin
                    n_err      = ST_PAYLOADLONG;
                    step_phase = PH_DROP;
                end
            end
            default: begin
                role = ROLE_DROP;
            end
        endcase
    end

    // Final status: first error, else the phase that was cut short, else empty or OK
    always_comb begin
        if (n_err != ST_OK) begin
            st = n_err;
        end else if (step_phase == PH_CODES) begin
            st = ST_CODES;
        end else if (step_phase == PH_PLEN) begin
            st = ST_LENGTH;
        end else if (step_phase == PH_PATH) begin
            st = ST_PATHSHORT;
        end else if (n_seen == '0) begin
            st = ST_EMPTY;
        end else begin
            st = ST_OK;
        end
        n_phase = i_last ? PH_HEADER : step_phase;
    end

    // Build the result beat; summary fields only on the final byte
    always_comb begin
        o_res                  = '0;
        o_res.byte_role        = role;
        o_res.byte_out         = i_byte;
        o_res.status           = ST_OK;
        if (i_last) begin
            o_res.packet_done      = 1'b1;
            o_res.status           = st;
            o_res.route_type       = n_route;
            o_res.payload_kind     = n_kind;
            o_res.hop_cnt          = n_hops;
            o_res.hash_len         = n_hash;
            o_res.transport_first  = n_code1;
            o_res.transport_second = n_code2;
            o_res.payload_length   = n_seen;
        end
    end

    // Hold state until a byte steps through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_sub      <= '0;
            r_path_rem <= '0;
            r_seen     <= '0;
            r_err      <= ST_OK;
            r_route    <= '0;
            r_kind     <= '0;
            r_hops     <= '0;
            r_hash     <= 2'd1;
            r_code1    <= '0;
            r_code2    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_sub      <= n_sub;
            r_path_rem <= n_path_rem;
            r_seen     <= n_seen;
            r_err      <= n_err;
            r_route    <= n_route;
            r_kind     <= n_kind;
            r_hops     <= n_hops;
            r_hash     <= n_hash;
            r_code1    <= n_code1;
            r_code2    <= n_code2;
        end
    end

endmodule

/* rtl/core/mesh_packet_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// mesh_packet_header_parser_unit
// Byte-serial mesh packet header parser: tags each byte with its role and
// reports status and header fields on the final byte.
// ----------------------------------------------------------------------------
// Path: an accepted byte goes through the input register, then the result register.
// Throughput: 1 byte per cycle while the result side is ready; the per-byte parse
// update between the input register and the result register is the only loop.
// Reset: synchronous, active low; clears the parse state to "expect header"
// and sets the path limit to 64 bytes and the payload limit to 184 bytes.
module mesh_packet_header_parser_unit
    import mphp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    mphp_in_if.sink          i_in,
    mphp_out_if.source       o_out
);

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_vld;
    t_result           r_out;
    logic [PATH_W-1:0] r_max_path;
    logic [LEN_W-1:0]  r_max_payload;

    logic              step;
    t_result           res;

    // Move the held byte on when the result register is free or drains
    assign step       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_path    <= MAX_PATH_RST;
            r_max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_PATH:    r_max_path    <= i_cfg_data[PATH_W-1:0];
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.end_of_packet;
        end
    end

    mphp_parse_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_max_path    (r_max_path),
        .i_max_payload (r_max_payload),
        .o_res         (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.byte_role        = r_out.byte_role;
    assign o_out.byte_out         = r_out.byte_out;
    assign o_out.packet_done      = r_out.packet_done;
    assign o_out.status           = r_out.status;
    assign o_out.route_type       = r_out.route_type;
    assign o_out.payload_kind     = r_out.payload_kind;
    assign o_out.hop_cnt          = r_out.hop_cnt;
    assign o_out.hash_len         = r_out.hash_len;
    assign o_out.transport_first  = r_out.transport_first;
    assign o_out.transport_second = r_out.transport_second;
    assign o_out.payload_length   = r_out.payload_length;

endmodule

/* bench/tb_mesh_packet_header_parser_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mesh_packet_header_parser_unit
// Drives byte streams of mesh packets into the parser: first a short directed
// set, then random packets under several limit settings. Most packets are
// well formed, and some are cut short, malformed or plain noise. A byte-level
// parse tracker predicts the role of every byte and the final status and
// fields. Each result beat is checked against it in order.
// ----------------------------------------------------------------------------
module tb_mesh_packet_header_parser_unit
    import mphp_pkg::*;
();

class parse_scoreboard;
    // Limits as last written
    logic [PATH_W-1:0] max_path;
    logic [LEN_W-1:0]  max_payload;

    // Per-packet parse state
    t_phase            phase;
    logic [7:0]        sub_cnt;
    logic [PATH_W-1:0] path_left;
    logic [LEN_W-1:0]  seen;
    t_status           err;
    logic [1:0]        route;
    logic [3:0]        kind;
    logic [5:0]        hops;
    logic [1:0]        hash;
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;

    t_result expected_q[$];
    int      failures;

    function new();
        max_path    = MAX_PATH_RST;
        max_payload = MAX_PAYLOAD_RST;
        failures    = 0;
        clear_packet();
    endfunction

    function void clear_packet();
        phase     = PH_HEADER;
        sub_cnt   = '0;
        path_left = '0;
        seen      = '0;
        err       = ST_OK;
        route     = '0;
        kind      = '0;
        hops      = '0;
        hash      = 2'd1;
        code_a    = '0;
        code_b    = '0;
    endfunction

    function void fail(t_status code);
        err   = code;
        phase = PH_DROP;
    endfunction

    function void set_limit(t_cfg_idx idx, logic [CFG_W-1:0] value);
        if (idx == CFG_MAX_PATH) begin
            max_path = value[PATH_W-1:0];
        end else begin
            max_payload = value[LEN_W-1:0];
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Advance the parse by one accepted byte and queue the beat it must produce
    function void note_byte(logic [7:0] b, logic eop);
        t_result    r;
        logic [2:0] hs;
        logic [7:0] nbytes;
        logic       over;
        r = '0;
        r.byte_role = ROLE_DROP;
        case (phase)
            PH_HEADER: begin
                clear_packet();
                r.byte_role = ROLE_HEADER;
                route = b[1:0];
                kind  = b[5:2];
                if (b[7:6] != 2'b00) begin
                    fail(ST_VERSION);
                end else if (route == 2'd0 || route == 2'd3) begin
                    phase = PH_CODES;
                end else begin
                    phase = PH_PLEN;
                end
            end
            PH_CODES: begin
                r.byte_role = ROLE_CODE;
                if (sub_cnt == 0)      code_a[7:0]  = b;
                else if (sub_cnt == 1) code_a[15:8] = b;
                else if (sub_cnt == 2) code_b[7:0]  = b;
                else                   code_b[15:8] = b;
                sub_cnt = sub_cnt + 8'd1;
                if (sub_cnt >= 4) phase = PH_PLEN;
            end
            PH_PLEN: begin
                r.byte_role = ROLE_PLEN;
                hs   = {1'b0, b[7:6]} + 3'd1;
                hops = b[5:0];
                hash = hs[1:0];
                if (hs == 3'd4) begin
                    fail(ST_HASHSIZE);
                end else begin
                    nbytes = 8'(hops) * 8'(hs);
                    if (nbytes > max_path) begin
                        fail(ST_PATHLONG);
                    end else begin
                        path_left = nbytes;
                        phase = (nbytes != 0) ? PH_PATH : PH_PAYLOAD;
                    end
                end
            end
            PH_PATH: begin
                r.byte_role = ROLE_PATH;
                if (path_left != 0) path_left = path_left - 8'd1;
                if (path_left == 0) phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                r.byte_role = ROLE_PAYLOAD;
                over = (seen >= max_payload);
                if (seen != PAYLOAD_SAT) seen = seen + 10'd1;
                if (over) fail(ST_PAYLOADLONG);
            end
            default: begin
            end
        endcase

        r.byte_out = b;
        if (eop) begin
            r.packet_done = 1'b1;
            if (err != ST_OK)             r.status = err;
            else if (phase == PH_CODES)   r.status = ST_CODES;
            else if (phase == PH_PLEN)    r.status = ST_LENGTH;
            else if (phase == PH_PATH)    r.status = ST_PATHSHORT;
            else if (seen == 0)           r.status = ST_EMPTY;
            else                          r.status = ST_OK;
            r.route_type       = route;
            r.payload_kind     = kind;
            r.hop_cnt          = hops;
            r.hash_len         = hash;
            r.transport_first  = code_a;
            r.transport_second = code_b;
            r.payload_length   = seen;
            phase = PH_HEADER;
        end
        expected_q = {expected_q, r};
    endfunction

    // Compare one result beat with the oldest queued prediction
    function void check_result(t_result got);
        t_result want;
        string   bad;
        if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result beat %p", got);
            return;
        end
        want = expected_q.pop_front();
        bad = "";
        if (got.byte_role        !== want.byte_role)        bad = {bad, " byte_role"};
        if (got.byte_out         !== want.byte_out)         bad = {bad, " byte_out"};
        if (got.packet_done      !== want.packet_done)      bad = {bad, " packet_done"};
        if (got.status           !== want.status)           bad = {bad, " status"};
        if (got.route_type       !== want.route_type)       bad = {bad, " route_type"};
        if (got.payload_kind     !== want.payload_kind)     bad = {bad, " payload_kind"};
        if (got.hop_cnt          !== want.hop_cnt)          bad = {bad, " hop_cnt"};
        if (got.hash_len         !== want.hash_len)         bad = {bad, " hash_len"};
        if (got.transport_first  !== want.transport_first)  bad = {bad, " transport_first"};
        if (got.transport_second !== want.transport_second) bad = {bad, " transport_second"};
        if (got.payload_length   !== want.payload_length)   bad = {bad, " payload_length"};
        if (bad != "") begin
            failures++;
            if (failures <= 10) begin
                $display("mismatch in%s: expected %p, got %p", bad, want, got);
            end
        end
    endfunction
endclass

    localparam int STALL_LIMIT = 2000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    mphp_in_if  in_if ();
    mphp_out_if out_if ();

    parse_scoreboard sb = new();

    int         in_idle_pct  = 34;
    int         out_idle_pct = 34;
    int         items_sent   = 0;
    logic [7:0] pkt_bytes[$];

    mesh_packet_header_parser_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Stall the result side at random
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_if.ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Track every accepted beat on both channels
    always @(posedge clk) begin : beat_monitor
        t_result got;
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                sb.note_byte(in_if.data_byte, in_if.end_of_packet);
            end
            if (out_if.valid && out_if.ready) begin
                got.byte_role        = t_role'(out_if.byte_role);
                got.byte_out         = out_if.byte_out;
                got.packet_done      = out_if.packet_done;
                got.status           = t_status'(out_if.status);
                got.route_type       = out_if.route_type;
                got.payload_kind     = out_if.payload_kind;
                got.hop_cnt          = out_if.hop_cnt;
                got.hash_len         = out_if.hash_len;
                got.transport_first  = out_if.transport_first;
                got.transport_second = out_if.transport_second;
                got.payload_length   = out_if.payload_length;
                sb.check_result(got);
            end
        end
    end

    // End the run if no beat moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[mesh_packet_header_parser_unit] ERROR");
        $finish;
    end

    // Offer one byte, with random idle cycles ahead of it, and hold until taken
    task automatic drive_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= b;
        in_if.end_of_packet <= eop;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_pkt();
        foreach (pkt_bytes[i]) drive_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    // Drop valid, let the last beat be noted, and wait until every predicted
    // beat has come out
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.set_limit(idx, value);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] path_val,
                              input logic [CFG_W-1:0] payload_val);
        drain();
        write_cfg(CFG_MAX_PATH, path_val);
        write_cfg(CFG_MAX_PAYLOAD, payload_val);
        cfg_we <= 1'b0;
    endtask

    // Build one random packet: mostly well formed, some cut short, some noise
    task automatic random_packet();
        int         pick;
        int         hs;
        int         cap;
        int         hops;
        int         n;
        int         r;
        int         keep;
        logic [7:0] hdr;
        pick = $urandom_range(0, 99);
        pkt_bytes.delete();
        if (pick >= 88) begin
            repeat ($urandom_range(1, 6)) pkt_bytes = {pkt_bytes, 8'($urandom)};
        end else begin
            hdr = {2'b00, 6'($urandom)};
            if (pick < 4) hdr[7:6] = 2'($urandom_range(1, 3));
            pkt_bytes = {pkt_bytes, hdr};
            if (hdr[1:0] == 2'd0 || hdr[1:0] == 2'd3) begin
                repeat (4) pkt_bytes = {pkt_bytes, 8'($urandom)};
            end

            hs  = ($urandom_range(0, 14) == 0) ? 4 : $urandom_range(1, 3);
            cap = (hs == 4) ? 63 : sb.max_path / hs;
            if (cap > 63) cap = 63;
            if ($urandom_range(0, 3) != 0 && cap > 5) cap = 5;
            hops = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, cap);
            pkt_bytes = {pkt_bytes, {2'(hs - 1), 6'(hops)}};
            if (hs < 4 && hops * hs <= sb.max_path) begin
                repeat (hops * hs) pkt_bytes = {pkt_bytes, 8'($urandom)};
            end

            r = $urandom_range(0, 29);
            if (r == 0 && sb.max_payload <= 200) begin
                n = sb.max_payload + 1 + $urandom_range(0, 1);
            end else if (r == 1) begin
                n = 0;
            end else begin
                cap = (sb.max_payload < 12) ? int'(sb.max_payload) : 12;
                if (cap == 0) cap = 1;
                n = $urandom_range(1, cap);
            end
            repeat (n) pkt_bytes = {pkt_bytes, 8'($urandom)};

            if (pick >= 70) begin
                keep = $urandom_range(1, pkt_bytes.size());
                while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
            end
        end
        send_pkt();
    endtask

    task automatic random_items(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) random_packet();
    endtask

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_MAX_PATH;
        cfg_data            <= '0;
        in_if.valid         <= 1'b0;
        in_if.data_byte     <= '0;
        in_if.end_of_packet <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets under the reset limits
        pkt_bytes = {8'hC0};                       send_pkt();  // bad version alone
        pkt_bytes = {8'h40, 8'h12};                send_pkt();  // bad version, rest dropped
        pkt_bytes = {8'h00, 8'hAB, 8'hCD};         send_pkt();  // codes cut short
        pkt_bytes = {8'h05};                       send_pkt();  // no path length byte
        pkt_bytes = {8'h02, 8'hFF};                send_pkt();  // reserved hash size
        pkt_bytes = {8'h01, 8'hBF};                send_pkt();  // path too long
        pkt_bytes = {8'h02, 8'h02, 8'h11};         send_pkt();  // path cut short
        pkt_bytes = {8'h01, 8'h00};                send_pkt();  // empty payload
        pkt_bytes = {8'h3F, 8'h34, 8'h12, 8'hCD, 8'hAB, 8'h41, 8'hAA, 8'h55, 8'hFF};
        send_pkt();                                             // full transport packet
        random_items(55);

        // Zero limits: any path or payload byte is an error
        set_limits(10'd0, 10'd0);
        pkt_bytes = {8'h02, 8'h00, 8'h77};         send_pkt();  // payload too long
        pkt_bytes = {8'h01, 8'h01};                send_pkt();  // path too long
        random_items(35);

        // Widest limits, no idling: run the payload count into saturation
        set_limits(10'd255, 10'd1023);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        pkt_bytes = {8'h01, 8'h00};
        repeat (1024) pkt_bytes = {pkt_bytes, 8'($urandom)};
        send_pkt();
        random_items(45);
        in_idle_pct  = 34;
        out_idle_pct = 34;

        // Random path limit, small payload limit
        set_limits(10'($urandom_range(0, 255)), 10'($urandom_range(1, 8)));
        random_items(75);

        // Random limits, junk in the unused upper bits of the path limit
        set_limits({2'($urandom), 8'($urandom)}, 10'($urandom_range(1, 1023)));
        random_items(75);

        set_limits(10'd1, 10'd1);
        random_items(45);

        drain();
        repeat (8) @(posedge clk);
        if (sb.failures == 0) begin
            $display("[mesh_packet_header_parser_unit] OK");
        end else begin
            $display("[mesh_packet_header_parser_unit] ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/mphp_pkg.sv
rtl/core/mphp_if.sv
rtl/core/mphp_parse_core.sv
rtl/core/mesh_packet_header_parser_unit.sv
bench/tb_mesh_packet_header_parser_unit.sv
